FILE: hw/rtl/mips_alu_regfile_execute_assert.svh
// Assertion helpers shared by the RTL files.
`ifndef MIPS_ALU_REGFILE_EXECUTE_ASSERT_SVH
`define MIPS_ALU_REGFILE_EXECUTE_ASSERT_SVH

// Checked only while out of reset.
`define MARE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define MARE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/mare_pkg.sv
package mare_pkg;

  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_AW    = $clog2(REG_COUNT);
  localparam int unsigned DATA_W    = 32;

  // primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_SLTI  = 6'd10;
  localparam logic [5:0] OP_SLTIU = 6'd11;

  // R-type function codes
  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_SRA  = 6'd3;
  localparam logic [5:0] FN_SLLV = 6'd4;
  localparam logic [5:0] FN_SRLV = 6'd6;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_SLT  = 6'd42;
  localparam logic [5:0] FN_SLTU = 6'd43;

  typedef struct packed {
    logic [5:0]        opcode;
    logic [REG_AW-1:0] source_reg;
    logic [REG_AW-1:0] target_reg;
    logic [REG_AW-1:0] dest_reg;
    logic [4:0]        shift_amount;
    logic [5:0]        function_code;
    logic [15:0]       immediate;
  } inst_t;

  typedef struct packed {
    logic              wr;
    logic [REG_AW-1:0] dst;
    logic [DATA_W-1:0] val;
  } res_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_t;

endpackage

FILE: hw/rtl/mare_regfile.sv
`include "mips_alu_regfile_execute_assert.svh"

module mare_regfile import mare_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [REG_AW-1:0] rs_addr_i,
  input  logic [REG_AW-1:0] rt_addr_i,
  input  wr_t               wr_i,
  output logic [DATA_W-1:0] rs_data_o,
  output logic [DATA_W-1:0] rt_data_o
);

  logic [DATA_W-1:0]    mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] valid_q;
  logic [DATA_W-1:0]    rs_mem_q, rt_mem_q;
  logic [DATA_W-1:0]    fwd_q;
  logic                 rs_fwd_q, rt_fwd_q, rs_zero_q, rt_zero_q;
  logic                 rs_fwd_d, rt_fwd_d;

  // a write landing on the same edge as the read is taken from the write port
  assign rs_fwd_d = wr_i.en && (wr_i.addr == rs_addr_i);
  assign rt_fwd_d = wr_i.en && (wr_i.addr == rt_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rs_mem_q <= mem_q[rs_addr_i];
      rt_mem_q <= mem_q[rt_addr_i];
      fwd_q    <= wr_i.data;
    end
  end

  // entry 0 is never marked valid, so it always reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rs_fwd_q  <= 1'b0;
      rt_fwd_q  <= 1'b0;
      rs_zero_q <= 1'b1;
      rt_zero_q <= 1'b1;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rs_fwd_q  <= rs_fwd_d;
        rt_fwd_q  <= rt_fwd_d;
        rs_zero_q <= !rs_fwd_d && !valid_q[rs_addr_i];
        rt_zero_q <= !rt_fwd_d && !valid_q[rt_addr_i];
      end
    end
  end

  assign rs_data_o = rs_fwd_q ? fwd_q : (rs_zero_q ? '0 : rs_mem_q);
  assign rt_data_o = rt_fwd_q ? fwd_q : (rt_zero_q ? '0 : rt_mem_q);

  `MARE_ASSERT_ALWAYS(a_no_wr_reg0, clk_i, wr_i.en |-> (wr_i.addr != '0), "write to register zero")
  `MARE_ASSERT(a_wr_sets_valid, clk_i, rst_ni, wr_i.en |=> valid_q[$past(wr_i.addr)], "written entry not valid")
  `MARE_ASSERT(a_reg0_invalid, clk_i, rst_ni, !valid_q[0], "register zero marked valid")

endmodule

FILE: hw/rtl/mare_alu.sv
module mare_alu import mare_pkg::*; (
  input  inst_t             inst_i,
  input  logic [DATA_W-1:0] rs_val_i,
  input  logic [DATA_W-1:0] rt_val_i,
  output res_t              res_o
);

  logic [DATA_W-1:0] simm;
  logic [DATA_W-1:0] sum_imm;
  logic [4:0]        vsh;

  assign simm    = {{(DATA_W-16){inst_i.immediate[15]}}, inst_i.immediate};
  assign sum_imm = rs_val_i + simm;
  assign vsh     = rs_val_i[4:0];

  always_comb begin
    res_o = '0;
    case (inst_i.opcode)
      OP_RTYPE: begin
        res_o.wr  = 1'b1;
        res_o.dst = inst_i.dest_reg;
        case (inst_i.function_code)
          FN_SLL:  res_o.val = rt_val_i << inst_i.shift_amount;
          FN_SRL:  res_o.val = rt_val_i >> inst_i.shift_amount;
          FN_SRA:  res_o.val = DATA_W'($signed(rt_val_i) >>> inst_i.shift_amount);
          FN_SLLV: res_o.val = rt_val_i << vsh;
          FN_SRLV: res_o.val = rt_val_i >> vsh;
          FN_ADD,
          FN_ADDU: res_o.val = rs_val_i + rt_val_i;
          FN_SUB,
          FN_SUBU: res_o.val = rs_val_i - rt_val_i;
          FN_AND:  res_o.val = rs_val_i & rt_val_i;
          FN_OR:   res_o.val = rs_val_i | rt_val_i;
          FN_XOR:  res_o.val = rs_val_i ^ rt_val_i;
          FN_SLT:  res_o.val = DATA_W'($signed(rs_val_i) < $signed(rt_val_i));
          FN_SLTU: res_o.val = DATA_W'(rs_val_i < rt_val_i);
          default: res_o.val = '0;
        endcase
      end
      OP_ADDI,
      OP_ADDIU: begin
        res_o.wr  = 1'b1;
        res_o.dst = inst_i.target_reg;
        res_o.val = sum_imm;
      end
      OP_SLTI: begin
        res_o.wr  = 1'b1;
        res_o.dst = inst_i.target_reg;
        res_o.val = DATA_W'($signed(rs_val_i) < $signed(simm));
      end
      OP_SLTIU: begin
        res_o.wr  = 1'b1;
        res_o.dst = inst_i.target_reg;
        res_o.val = DATA_W'(rs_val_i < simm);
      end
      default: res_o = '0;
    endcase
  end

endmodule

FILE: hw/rtl/mips_alu_regfile_execute.sv
// Integer execute stage of a MIPS-like subset with its own 32 x 32-bit register
// file. One instruction word is taken per cycle unless m_axis_tready stalls a
// full pipeline, and each gives one result word: the accept edge reads rs and
// rt from the register file into registers, a later edge with the output free
// runs the ALU, writes the register file and loads the output register. A
// result written on the same edge that a following instruction reads is
// forwarded, so back-to-back dependent instructions see the new value.
// Register 0 reads as zero; all registers read as zero after reset (per-entry
// valid bits, no clearing pass). Writes to register 0 are reported in the result
// but not stored. Unknown opcodes return a result with tuser low and zero data.
`include "mips_alu_regfile_execute_assert.svh"

module mips_alu_regfile_execute import mare_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] opcode, [10:6] source_reg, [15:11] target_reg, [20:16] dest_reg,
  // [25:21] shift_amount, [31:26] function_code, [47:32] immediate
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] written_reg, [36:5] written_value, [39:37] zero
  output logic [39:0] m_axis_tdata,
  // [0] write_done
  output logic        m_axis_tuser
);

  inst_t             inst_q, inst_in;
  logic              s1_valid_q, s1_valid_d;
  logic              m_valid_q, m_valid_d;
  logic              m_done_q;
  logic [REG_AW-1:0] m_reg_q;
  logic [DATA_W-1:0] m_val_q;
  logic              advance, accept, s1_move;
  logic [DATA_W-1:0] rs_val, rt_val;
  res_t              res;
  wr_t               wr;

  assign inst_in.opcode        = s_axis_tdata[5:0];
  assign inst_in.source_reg    = s_axis_tdata[10:6];
  assign inst_in.target_reg    = s_axis_tdata[15:11];
  assign inst_in.dest_reg      = s_axis_tdata[20:16];
  assign inst_in.shift_amount  = s_axis_tdata[25:21];
  assign inst_in.function_code = s_axis_tdata[31:26];
  assign inst_in.immediate     = s_axis_tdata[47:32];

  assign advance       = !m_valid_q || m_axis_tready;
  assign s_axis_tready = advance || !s1_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s1_move       = s1_valid_q && advance;

  assign s1_valid_d = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign m_valid_d  = advance ? s1_valid_q : m_valid_q;

  assign wr.en   = s1_move && res.wr && (res.dst != '0);
  assign wr.addr = res.dst;
  assign wr.data = res.val;

  mare_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rs_addr_i (inst_in.source_reg),
    .rt_addr_i (inst_in.target_reg),
    .wr_i      (wr),
    .rs_data_o (rs_val),
    .rt_data_o (rt_val)
  );

  mare_alu u_alu (
    .inst_i   (inst_q),
    .rs_val_i (rs_val),
    .rt_val_i (rt_val),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      inst_q <= inst_in;
    end
    if (s1_move) begin
      m_done_q <= res.wr;
      m_reg_q  <= res.dst;
      m_val_q  <= res.val;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_done_q;
  assign m_axis_tdata  = {3'b000, m_val_q, m_reg_q};

  `MARE_ASSERT(a_stall_cause, clk_i, rst_ni, !s_axis_tready |-> (s1_valid_q && m_valid_q && !m_axis_tready), "input stalled without a full pipeline")
  `MARE_ASSERT(a_accept_fills, clk_i, rst_ni, accept |=> s1_valid_q, "accepted word not in stage")
  `MARE_ASSERT(a_nowrite_zero, clk_i, rst_ni, (s1_move && !res.wr) |=> (!m_axis_tuser && (m_axis_tdata == '0)), "non-writing result not zero")
  `MARE_ASSERT(a_move_shows, clk_i, rst_ni, s1_move |=> m_axis_tvalid, "stage moved but no result")

endmodule
